// ----- rtl/dtt_pkg.sv -----
`default_nettype none

package dtt_pkg;

   localparam int ENTRIES = 64;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int DL_W  = 32;
   localparam int ID_W  = 16;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_SCAN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_ADDED   = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_EXPIRED = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [DL_W-1:0] deadline;
      logic [ID_W-1:0] id;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/dtt_cell.sv -----
`default_nettype none

// One table slot: loads a new entry, takes its upper neighbour's entry, or holds.
module dtt_cell (
   input  wire logic                 clock,
   input  wire dtt_pkg::cell_ctl_type ctl,
   input  wire dtt_pkg::entry_type   wr_data,
   input  wire dtt_pkg::entry_type   nbr,
   output dtt_pkg::entry_type        q
);

   dtt_pkg::entry_type entry_ff;
   dtt_pkg::entry_type entry_in;

   always_comb begin
      if (ctl.write) begin
         entry_in = wr_data;
      end else if (ctl.shift) begin
         entry_in = nbr;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/deadline_task_table.sv -----
// deadline_task_table: table of pending delayed tasks held in a row of slot cells.
//
// Request channel (req_*): one transfer per command. req_tuser is the opcode
// (add or scan); req_tdata carries task id, delay and the current tick count.
// Response channel (rsp_*): rsp_tuser gives the result kind, rsp_tdata the id of
// an expired task, rsp_tlast marks the final response of a command.
//
// Add: one response in the cycle after the transfer (added, or dropped when full).
// Scan: the row of cells shifts one slot per cycle towards slot 0 while no step
// waits on the response slot; the head entry is checked, expired ids are sent
// out, survivors are re-written at the tail so order is kept. A scan of an empty
// table gives a single "none" response.
// One command is worked on at a time; req_tready is low during a scan.
//
// Reset (synchronous, active high) empties the table; slot contents are not
// cleared, only the entry count. A stalled receiver makes the response register
// hold its transfer; scan steps that must send an expired id wait until it is taken.

`default_nettype none

module deadline_task_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // task_id[15:0], delay_ticks[47:16], now_ticks[79:48]
   input  wire logic [0:0]  req_tuser,   // opcode[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // expired_id[15:0]
   output logic [1:0]       rsp_tuser,   // kind[1:0]
   output logic             rsp_tlast
);

   localparam int ENTRIES = dtt_pkg::ENTRIES;
   localparam int CNT_W   = dtt_pkg::CNT_W;
   localparam int IDX_W   = dtt_pkg::IDX_W;

   // request fields
   logic [15:0] req_id;
   logic [31:0] req_delay;
   logic [31:0] req_now;
   dtt_pkg::op_type req_op;

   assign req_id    = req_tdata[15:0];
   assign req_delay = req_tdata[47:16];
   assign req_now   = req_tdata[79:48];
   assign req_op    = dtt_pkg::op_type'(req_tuser[0]);

   // control state
   dtt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] live_ff, live_in;     // entry count
   logic [CNT_W-1:0] steps_ff, steps_in;   // slots left to check in this scan
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [31:0]        now_ff, now_in;
   logic [15:0]        pend_id_ff, pend_id_in;
   dtt_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic               rsp_last_ff, rsp_last_in;

   // cell row
   dtt_pkg::entry_type cell_q [ENTRIES];
   dtt_pkg::entry_type head;
   dtt_pkg::entry_type wr_data;
   logic [IDX_W-1:0]   wr_idx;
   logic               wr_en;
   logic               shift_en;

   logic out_free;
   logic req_accept;
   logic expired;
   logic step_ok;

   // emitted response
   logic              emit;
   dtt_pkg::kind_type emit_kind;
   logic [15:0]       emit_id;
   logic              emit_last;

   assign head       = cell_q[0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dtt_pkg::ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign expired    = head.deadline < now_ff;
   // a step that must push out the held expired id waits for the response slot
   assign step_ok    = !(expired && pend_valid_ff) || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtt_pkg::ST_IDLE: begin
            if (req_accept && req_op == dtt_pkg::OP_SCAN && live_ff != '0) begin
               state_in = dtt_pkg::ST_SCAN;
            end
         end
         dtt_pkg::ST_SCAN: begin
            if (step_ok && steps_ff == CNT_W'(1)) begin
               state_in = dtt_pkg::ST_FIN;
            end
         end
         dtt_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = dtt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtt_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control and responses
   always_comb begin
      live_in       = live_ff;
      steps_in      = steps_ff;
      now_in        = now_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      wr_en         = 1'b0;
      wr_idx        = IDX_W'(live_ff);
      wr_data       = head;
      shift_en      = 1'b0;
      emit          = 1'b0;
      emit_kind     = dtt_pkg::KIND_NONE;
      emit_id       = '0;
      emit_last     = 1'b1;
      case (state_ff)
         dtt_pkg::ST_IDLE: begin
            if (req_accept) begin
               emit = 1'b1;
               if (req_op == dtt_pkg::OP_ADD) begin
                  if (live_ff >= CNT_W'(ENTRIES)) begin
                     emit_kind = dtt_pkg::KIND_FULL;
                  end else begin
                     emit_kind        = dtt_pkg::KIND_ADDED;
                     wr_en            = 1'b1;
                     wr_data.deadline = req_now + req_delay;
                     wr_data.id       = req_id;
                     live_in          = live_ff + CNT_W'(1);
                  end
               end else begin
                  // scan of an empty table answers at once
                  emit          = (live_ff == '0);
                  emit_kind     = dtt_pkg::KIND_NONE;
                  now_in        = req_now;
                  steps_in      = live_ff;
                  pend_valid_in = 1'b0;
               end
            end
         end
         dtt_pkg::ST_SCAN: begin
            if (step_ok) begin
               shift_en = 1'b1;
               steps_in = steps_ff - CNT_W'(1);
               wr_idx   = IDX_W'(live_ff - CNT_W'(1));
               if (expired) begin
                  // previous expired id is now known not to be the last one
                  emit          = pend_valid_ff;
                  emit_kind     = dtt_pkg::KIND_EXPIRED;
                  emit_id       = pend_id_ff;
                  emit_last     = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_id_in    = head.id;
                  live_in       = live_ff - CNT_W'(1);
               end else begin
                  wr_en = 1'b1;   // survivor goes back in at the tail
               end
            end
         end
         dtt_pkg::ST_FIN: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_kind     = pend_valid_ff ? dtt_pkg::KIND_EXPIRED : dtt_pkg::KIND_NONE;
               emit_id       = pend_valid_ff ? pend_id_ff : 16'd0;
               emit_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_id_in    = emit_id;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtt_pkg::ST_IDLE;
         live_ff       <= '0;
         steps_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         steps_ff      <= steps_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      pend_id_ff  <= pend_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   // row of slots; slot i takes slot i+1 on a shift, top slot takes slot 0
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      dtt_pkg::cell_ctl_type ctl;
      dtt_pkg::entry_type    nbr;

      assign ctl.shift = shift_en;
      assign ctl.write = wr_en && (wr_idx == IDX_W'(i));

      if (i < ENTRIES - 1) begin : g_mid
         assign nbr = cell_q[i+1];
      end else begin : g_top
         assign nbr = cell_q[0];
      end

      dtt_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .wr_data (wr_data),
         .nbr     (nbr),
         .q       (cell_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/dtt_checker.sv -----
`default_nettype none

module dtt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // add gets its answer in the next cycle
   a_add_answer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == dtt_pkg::OP_ADD |=>
         rsp_tvalid && rsp_tlast &&
         (rsp_tuser == dtt_pkg::KIND_ADDED || rsp_tuser == dtt_pkg::KIND_FULL))
      else $error("add not answered");

   // only expired responses carry an id
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != dtt_pkg::KIND_EXPIRED |-> rsp_tdata == 16'd0)
      else $error("non-expired response with id");

   // single-response kinds always end their command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != dtt_pkg::KIND_EXPIRED |-> rsp_tlast)
      else $error("single response without last");

endmodule

bind deadline_task_table dtt_checker u_dtt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- tb/deadline_task_checker.sv -----
`default_nettype none

module deadline_task_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,   // task_id[15:0], delay_ticks[47:16], now_ticks[79:48]
   input  wire logic [0:0]  req_tuser,   // opcode[0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // expired_id[15:0]
   input  wire logic [1:0]  rsp_tuser,   // kind[1:0]
   input  wire logic        rsp_tlast,
   output int               fail_count,
   output int               outstanding,
   output int               expired_seen,
   output int               dropped_seen
);

   typedef struct packed {
      dtt_pkg::kind_type        kind;
      logic [dtt_pkg::ID_W-1:0] id;
      logic                     last;
   } outcome_type;

   outcome_type              due_q[$];
   logic [dtt_pkg::DL_W-1:0] deadline_tab [dtt_pkg::ENTRIES];
   logic [dtt_pkg::ID_W-1:0] task_tab [dtt_pkg::ENTRIES];
   int                       task_count;

   function automatic void push_outcome(dtt_pkg::kind_type kind,
                                        logic [dtt_pkg::ID_W-1:0] id, logic last);
      outcome_type o;
      o.kind = kind;
      o.id   = id;
      o.last = last;
      due_q.push_back(o);
   endfunction

   // Table update and the responses one command gives.
   function automatic void apply_command(dtt_pkg::op_type op, logic [dtt_pkg::ID_W-1:0] id,
                                         logic [dtt_pkg::DL_W-1:0] delay,
                                         logic [dtt_pkg::DL_W-1:0] now);
      logic [dtt_pkg::ID_W-1:0] gone_ids[$];
      int                       keep;
      keep = 0;
      if (op == dtt_pkg::OP_ADD) begin
         if (task_count >= dtt_pkg::ENTRIES) begin
            push_outcome(dtt_pkg::KIND_FULL, '0, 1'b1);
         end else begin
            deadline_tab[task_count] = now + delay;
            task_tab[task_count]     = id;
            task_count++;
            push_outcome(dtt_pkg::KIND_ADDED, '0, 1'b1);
         end
      end else begin
         // plain unsigned compare, survivors slide down in order
         for (int i = 0; i < task_count; i++) begin
            if (deadline_tab[i] < now) begin
               gone_ids.push_back(task_tab[i]);
            end else begin
               deadline_tab[keep] = deadline_tab[i];
               task_tab[keep]     = task_tab[i];
               keep++;
            end
         end
         task_count = keep;
         if (gone_ids.size() == 0) begin
            push_outcome(dtt_pkg::KIND_NONE, '0, 1'b1);
         end else begin
            foreach (gone_ids[k])
               push_outcome(dtt_pkg::KIND_EXPIRED, gone_ids[k], k == gone_ids.size() - 1);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      int          errs;
      errs = 0;
      if (reset) begin
         due_q.delete();
         task_count = 0;
         fail_count   <= 0;
         expired_seen <= 0;
         dropped_seen <= 0;
      end else begin
         // responses first: one can never belong to a command taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser == dtt_pkg::KIND_EXPIRED) expired_seen <= expired_seen + 1;
            if (rsp_tuser == dtt_pkg::KIND_FULL) dropped_seen <= dropped_seen + 1;
            if (due_q.size() == 0) begin
               $error("unexpected response: kind %0d id %h last %b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               errs++;
            end else begin
               want = due_q.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  errs++;
               end
               if (rsp_tdata !== want.id) begin
                  $error("expired_id: expected %h, got %h", want.id, rsp_tdata);
                  errs++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_command(dtt_pkg::op_type'(req_tuser[0]), req_tdata[15:0],
                          req_tdata[47:16], req_tdata[79:48]);
         fail_count <= fail_count + errs;
      end
      outstanding <= due_q.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_deadline_task_table.sv -----
`default_nettype none

// Stimulus and verdict for the task table; all prediction and comparison
// lives in the checker instance beside the block.
module tb_deadline_task_table;

   localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer before giving up
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int TAIL_CYCLES = 100;   // quiet time after the last response

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;   // task_id[15:0], delay_ticks[47:16], now_ticks[79:48]
   logic [0:0]  req_tuser  = '0;   // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // expired_id[15:0]
   logic [1:0]  rsp_tuser;         // kind[1:0]
   logic        rsp_tlast;

   int fail_count, outstanding, expired_seen, dropped_seen;

   // receiver hold-off request (raised and dropped by the stimulus) and its acknowledge
   logic hold_rsp = 1'b0;
   logic holding  = 1'b0;

   int          idle_cycles = 0;
   int          burst_left  = 0;
   int          adds_sent   = 0;
   int          scans_sent  = 0;
   logic [31:0] tick        = '0;  // free-running tick as the sender sees it

   deadline_task_table i_dut (.*);

   deadline_task_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one command and wait for its transfer. Commands go out in bursts;
   // a gap with tvalid low opens each burst, so tvalid never drops and
   // rises within one step.
   task automatic send_item(input dtt_pkg::op_type op, input logic [dtt_pkg::ID_W-1:0] id,
                            input logic [dtt_pkg::DL_W-1:0] delay,
                            input logic [dtt_pkg::DL_W-1:0] now);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 10)) @(posedge clock);
         // now and then a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {now, delay, id};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left == 0) req_tvalid <= 1'b0;
      if (op == dtt_pkg::OP_SCAN) scans_sent++;
      else adds_sent++;
   endtask

   // Sender pause: nothing offered until every predicted response is in.
   task automatic wait_drained();
      if (burst_left != 0) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One random command around the running tick. Most adds get long delays so
   // the table fills; a share expire soon, wrap past 2^32 or carry a stray tick.
   task automatic random_item(input int scan_pct, input int step_max);
      logic [dtt_pkg::ID_W-1:0] tid;
      logic [dtt_pkg::DL_W-1:0] dly;
      logic [dtt_pkg::DL_W-1:0] now;
      int                       pick;
      tick = tick + $urandom_range(0, step_max);
      now  = tick;
      tid  = dtt_pkg::ID_W'($urandom());
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < scan_pct) begin
         if (pick < 5) now = $urandom();   // out-of-sequence tick
         send_item(dtt_pkg::OP_SCAN, tid, dtt_pkg::DL_W'($urandom()), now);
      end else begin
         if (pick < 10) dly = '0;
         else if (pick < 25) dly = $urandom();
         else if (pick < 35) dly = $urandom_range(0, 100);
         else dly = $urandom_range(2000, 1000000);
         if (pick >= 97) now = $urandom();
         send_item(dtt_pkg::OP_ADD, tid, dly, now);
      end
   endtask

   // Receiver: ready runs of random length, stalls of random length (sometimes
   // none), and one long hold-off on request.
   initial begin : rsp_pacing
      int run_len;
      int stall_len;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            holding    <= 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding <= 1'b0;
         end
         run_len   = $urandom_range(1, 20);
         stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         if (stall_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Watchdog: a stretch with no transfer on either channel means a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table scan, id/delay/tick extremes, wrapped deadlines,
      // deadline equal to now (kept: strict compare), several expiring in one
      // scan with the ones between kept in order.
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_item(dtt_pkg::OP_ADD,  16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_item(dtt_pkg::OP_ADD,  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(dtt_pkg::OP_ADD,  16'h1234, 32'h0000_0200, 32'hFFFF_FF00);   // wraps to 0x100
      send_item(dtt_pkg::OP_ADD,  16'h00AA, 32'h0000_0010, 32'h0000_0100);
      send_item(dtt_pkg::OP_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);   // equal, none out
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'h0000_0100);
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'h0000_0111);   // two at once
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(dtt_pkg::OP_ADD,  16'h5A5A, 32'h0000_0005, 32'hFFFF_FFFF);   // wraps to 4
      send_item(dtt_pkg::OP_ADD,  16'hA5A5, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(dtt_pkg::OP_ADD,  16'h0007, 32'h0000_0001, 32'h0000_000A);
      send_item(dtt_pkg::OP_ADD,  16'h0008, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'h0000_000B);
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'h0000_000C);
      send_item(dtt_pkg::OP_SCAN, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      wait_drained();

      // Fill: mostly adds until the table has turned a few away.
      tick = $urandom_range(0, 1000);
      for (int n = 0; n < 200 && dropped_seen < 3; n++)
         random_item(8, 50);
      wait_drained();

      // Drain: receiver held off while a scan over a full table starts, so the
      // response stage backs up and the request side stalls behind it.
      hold_rsp <= 1'b1;
      do @(posedge clock); while (!holding);
      hold_rsp <= 1'b0;
      tick = tick + 300000;
      send_item(dtt_pkg::OP_SCAN, dtt_pkg::ID_W'($urandom()), dtt_pkg::DL_W'($urandom()), tick);
      for (int n = 0; n < 30; n++)
         random_item(50, 60000);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d adds and %0d scans; %0d tasks expired, %0d adds refused as full",
               adds_sent, scans_sent, expired_seen, dropped_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/dtt_pkg.sv
rtl/dtt_cell.sv
rtl/deadline_task_table.sv
rtl/dtt_checker.sv
tb/deadline_task_checker.sv
tb/tb_deadline_task_table.sv
